// ===== hw/rtl/lrs_pkg.sv =====
package lrs_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 4;

  localparam int PT_W    = $clog2(MAX_POINTS);
  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int ADDR_W  = PT_W + DIM_W;
  localparam int COORD_W = 16;
  localparam int CNT_W   = 16;
  localparam int NPT_W   = 11;
  localparam int PROD_W  = CNT_W + PT_W;
  localparam int STEP_W  = 5;
  localparam int CFG_W   = 16;

  localparam logic CFG_OUT_COUNT   = 1'b0;
  localparam logic CFG_POINT_COUNT = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_BASE,
    ST_DIV_FRAC,
    ST_RD0,
    ST_RD1,
    ST_MULT,
    ST_FIN
  } lrs_state_t;

  typedef struct packed {
    logic              go;
    logic [CNT_W-1:0]  rem_init;
    logic [CNT_W-1:0]  bits_in;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quo;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/trajectory_linear_resampler.sv =====
// Timing: a load gives no result; an out-of-range query strobes its result in the
// cycle after the transfer; an in-range query strobes its result after the bit-serial
// divider (10 steps for the base point, 16 for the fraction), two store reads, the
// multiply and a final step. No item is taken while a query is busy.
// Throughput: one load per cycle while idle. The receiver cannot stall.
// Reset (rst, synchronous): idle, out_count = 1, point_count = 1; store undefined.
module trajectory_linear_resampler
  import lrs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [PT_W-1:0]           point_index,
  input  logic [DIM_W-1:0]          dim_index,
  input  logic signed [COORD_W-1:0] coord_in,
  input  logic [CNT_W-1:0]          sample_index,
  output logic                      done,
  output logic signed [COORD_W-1:0] coord_out,
  output logic                      range_error,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  // Configuration registers
  logic [CNT_W-1:0] out_count;
  logic [NPT_W-1:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count   <= CNT_W'(1);
      point_count <= NPT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_COUNT:   out_count   <= cfg_data;
        CFG_POINT_COUNT: point_count <= cfg_data[NPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective point count: zero acts as one, saturate at the store depth.
  logic [NPT_W-1:0] n_eff;
  always_comb begin
    if (point_count == '0) begin
      n_eff = NPT_W'(1);
    end else if (point_count > NPT_W'(MAX_POINTS)) begin
      n_eff = NPT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  lrs_state_t state, state_next;

  // Query context and datapath registers
  logic [CNT_W-1:0]          sample_r;
  logic [DIM_W-1:0]          dim_r;
  logic [PT_W-1:0]           base_r;
  logic [CNT_W-1:0]          frac_r;
  logic signed [COORD_W-1:0] p0_r;
  logic signed [COORD_W:0]   diff_r;
  logic signed [2*COORD_W+1:0] prodd_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Shared divider
  div_req_t dreq;
  div_rsp_t drsp;

  lrs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .divisor (out_count),
    .req     (dreq),
    .rsp     (drsp)
  );

  // Point store: loads write straight from the ports on the transfer edge.
  logic                      st_re;
  logic [ADDR_W-1:0]         st_raddr;
  logic signed [COORD_W-1:0] st_rdata;

  lrs_store u_store (
    .clk   (clk),
    .we    (accept && (kind == KIND_LOAD)),
    .waddr ({point_index, dim_index}),
    .wdata (coord_in),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // sample * n fits PROD_W bits since sample < 2^16 and n <= MAX_POINTS.
  logic [CNT_W+NPT_W-1:0] prod_full;
  logic [PROD_W-1:0]      prod;
  assign prod_full = sample_r * n_eff;
  assign prod      = prod_full[PROD_W-1:0];

  // Interpolation result: p0 plus the floor of the scaled step, kept to 16 bits.
  logic                      use_p0;
  logic signed [COORD_W-1:0] interp;
  assign use_p0 = (frac_r == '0) || ({1'b0, base_r} >= (n_eff - NPT_W'(1)));
  assign interp = p0_r + prodd_r[2*COORD_W-1:COORD_W];

  logic                      done_next;
  logic                      range_error_next;
  logic signed [COORD_W-1:0] coord_out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      range_error <= 1'b0;
    end else begin
      state       <= state_next;
      done        <= done_next;
      range_error <= range_error_next;
    end
  end

  always_ff @(posedge clk) begin
    coord_out <= coord_out_next;
  end

  always_comb begin
    state_next       = state;
    done_next        = 1'b0;
    range_error_next = 1'b0;
    coord_out_next   = coord_out;
    dreq.go          = 1'b0;
    dreq.rem_init    = '0;
    dreq.bits_in     = '0;
    dreq.steps       = '0;
    st_re            = 1'b0;
    st_raddr         = {base_r, dim_r};
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_QUERY)) begin
          if (sample_index >= out_count) begin
            // Out of range: answer at once, no arithmetic.
            done_next        = 1'b1;
            range_error_next = 1'b1;
            coord_out_next   = '0;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // Base = prod / out_count. The quotient is below 2^PT_W, so the high
        // part already sits below the divisor and only PT_W steps remain.
        dreq.go       = 1'b1;
        dreq.rem_init = prod[PROD_W-1:PT_W];
        dreq.bits_in  = {prod[PT_W-1:0], (CNT_W-PT_W)'(0)};
        dreq.steps    = STEP_W'(PT_W);
        state_next    = ST_DIV_BASE;
      end
      ST_DIV_BASE: begin
        if (drsp.done) begin
          // Fraction = (rem << 16) / out_count: shift in 16 zeros.
          dreq.go       = 1'b1;
          dreq.rem_init = drsp.rem;
          dreq.bits_in  = '0;
          dreq.steps    = STEP_W'(CNT_W);
          state_next    = ST_DIV_FRAC;
        end
      end
      ST_DIV_FRAC: begin
        if (drsp.done) begin
          st_re      = 1'b1;
          st_raddr   = {base_r, dim_r};
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        // Fetch the next point; only used when base is not the last point.
        st_re      = 1'b1;
        st_raddr   = {base_r + PT_W'(1), dim_r};
        state_next = ST_RD1;
      end
      ST_RD1: begin
        state_next = ST_MULT;
      end
      ST_MULT: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        done_next      = 1'b1;
        coord_out_next = use_p0 ? p0_r : interp;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath captures, gated by the sequencer state.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample_r <= sample_index;
        dim_r    <= dim_index;
      end
      ST_DIV_BASE: begin
        if (drsp.done) begin
          base_r <= drsp.quo[PT_W-1:0];
        end
      end
      ST_DIV_FRAC: begin
        if (drsp.done) begin
          frac_r <= drsp.quo;
        end
      end
      ST_RD0: begin
        p0_r <= st_rdata;
      end
      ST_RD1: begin
        diff_r <= (COORD_W+1)'(st_rdata) - (COORD_W+1)'(p0_r);
      end
      ST_MULT: begin
        prodd_r <= diff_r * $signed({1'b0, frac_r});
      end
      default: ;
    endcase
  end

  // A result is never strobed while a query is still at work.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Leaving a query always delivers its result.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("query finished without a result");

  // A load transfer never starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_LOAD)) |=> !busy)
    else $error("load left the block busy");

  // The error flag only appears on a result strobe.
  assert property (@(posedge clk) disable iff (rst) range_error |-> done)
    else $error("range_error without result strobe");

endmodule

// ===== hw/rtl/lrs_div.sv =====
module lrs_div
  import lrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] divisor,
  input  div_req_t         req,
  output div_rsp_t         rsp
);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  sh;
  logic [CNT_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic              done;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem, sh[CNT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= req.rem_init;
      sh  <= req.bits_in;
      quo <= '0;
    end else if (run) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      sh  <= {sh[CNT_W-2:0], 1'b0};
      quo <= {quo[CNT_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ===== hw/rtl/lrs_store.sv =====
module lrs_store
  import lrs_pkg::*;
(
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic signed [COORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic signed [COORD_W-1:0] rdata
);

  logic signed [COORD_W-1:0] mem [MAX_POINTS*MAX_DIMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import lrs_pkg::*;

  localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
  // Idle cycles with no transfer and no result before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      range_err;
  } sample_t;

  // Mirror of the resampler: point store, the two count registers, and the
  // queue of samples still owed by the block.
  class resample_board;
    logic [COORD_W-1:0] store [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    int unsigned        out_count;
    int unsigned        point_count;
    sample_t            owed [$];
    int unsigned        errors;
    int unsigned        loads;
    int unsigned        queries;
    int unsigned        out_of_range;

    function new();
      out_count = 1;
      point_count = 1;
      errors = 0;
      loads = 0;
      queries = 0;
      out_of_range = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(logic idx, int unsigned val);
      if (idx == CFG_OUT_COUNT) out_count = val & 32'hFFFF;
      else point_count = val & 32'h7FF;
    endfunction

    // Zero counts as one point; anything past the store saturates.
    function int unsigned points_used();
      if (point_count == 0) return 1;
      if (point_count > MAX_POINTS) return MAX_POINTS;
      return point_count;
    endfunction

    function int unsigned base_of(int unsigned sample);
      longint unsigned prod;
      prod = longint'(sample) * points_used();
      return 32'(prod / out_count);
    endfunction

    function bit is_written(int unsigned pt, int unsigned dim);
      return written[pt * MAX_DIMS + dim];
    endfunction

    function longint coord_at(int unsigned pt, int unsigned dim);
      int unsigned addr;
      addr = pt * MAX_DIMS + dim;
      if (addr >= STORE_DEPTH) return 0;
      return longint'($signed(store[addr]));
    endfunction

    // Note one transfer: update the store on a load, owe a sample on a query.
    function void note(logic kind, logic [PT_W-1:0] pt, logic [DIM_W-1:0] dim,
                       logic [COORD_W-1:0] coord, logic [CNT_W-1:0] sample);
      sample_t         s;
      int unsigned     n;
      int unsigned     base;
      longint unsigned prod;
      longint unsigned rem;
      longint unsigned frac;
      longint          p0;
      longint          p1;
      longint          res;
      int unsigned     d;
      d = dim % MAX_DIMS;
      if (kind == KIND_LOAD) begin
        loads++;
        if (pt < MAX_POINTS) begin
          store[pt * MAX_DIMS + d] = coord;
          written[pt * MAX_DIMS + d] = 1;
        end
        return;
      end
      queries++;
      if (sample >= out_count) begin
        out_of_range++;
        s.coord = '0;
        s.range_err = 1'b1;
        owed.push_back(s);
        return;
      end
      n = points_used();
      prod = longint'(sample) * n;
      base = 32'(prod / out_count);
      rem = prod % out_count;
      frac = (rem << 16) / out_count;
      p0 = coord_at(base, d);
      if (frac == 0 || base >= n - 1) begin
        res = p0;
      end else begin
        p1 = coord_at(base + 1, d);
        res = p0 + (((p1 - p0) * longint'(frac)) >>> 16);
      end
      s.coord = res[COORD_W-1:0];
      s.range_err = 1'b0;
      owed.push_back(s);
    endfunction

    function void check(logic signed [COORD_W-1:0] coord, logic range_err);
      sample_t s;
      if (owed.size() == 0) begin
        $error("unexpected result: coord_out %0d range_error %0b", coord, range_err);
        errors++;
        return;
      end
      s = owed.pop_front();
      if (coord !== s.coord) begin
        $error("coord_out mismatch: expected %0d, got %0d", s.coord, coord);
        errors++;
      end
      if (range_err !== s.range_err) begin
        $error("range_error mismatch: expected %0b, got %0b", s.range_err, range_err);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void close();
      if (owed.size() != 0) begin
        $error("%0d queries never answered", owed.size());
        errors += owed.size();
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      kind;
  logic [PT_W-1:0]           point_index;
  logic [DIM_W-1:0]          dim_index;
  logic signed [COORD_W-1:0] coord_in;
  logic [CNT_W-1:0]          sample_index;
  logic                      done;
  logic signed [COORD_W-1:0] coord_out;
  logic                      range_error;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  resample_board board;
  int unsigned   idle_cycles;
  int unsigned   calm_left;
  int unsigned   settings_used;

  trajectory_linear_resampler DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .point_index  (point_index),
    .dim_index    (dim_index),
    .coord_in     (coord_in),
    .sample_index (sample_index),
    .done         (done),
    .coord_out    (coord_out),
    .range_error  (range_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check every strobed result against the oldest owed sample.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.check(coord_out, range_error);
  end

  // Hang detector: any transfer or result clears the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no transfer or result for %0d cycles", HANG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Gap before the next transfer: mostly none or short, some long, and
  // occasional calm stretches of back-to-back transfers.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send(logic k, logic [PT_W-1:0] pt, logic [DIM_W-1:0] dim,
                      logic [COORD_W-1:0] coord, logic [CNT_W-1:0] sample);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    point_index  <= pt;
    dim_index    <= dim;
    coord_in     <= coord;
    sample_index <= sample;
    do @(posedge clk); while (busy);
    board.note(k, pt, dim, coord, sample);
  endtask

  task automatic load(int unsigned pt, int unsigned dim, logic [COORD_W-1:0] coord);
    send(KIND_LOAD, PT_W'(pt), DIM_W'(dim), coord, CNT_W'($urandom_range(0, 65535)));
  endtask

  // Query one sample; first fill any store entry the interpolation would read.
  task automatic query(int unsigned sample, int unsigned dim);
    int unsigned base;
    if (sample < board.out_count) begin
      base = board.base_of(sample);
      for (int unsigned p = base; p <= base + 1; p++) begin
        if (p < MAX_POINTS && !board.is_written(p, dim))
          load(p, dim, COORD_W'($urandom_range(0, 65535)));
      end
    end
    send(KIND_QUERY, PT_W'($urandom_range(0, MAX_POINTS - 1)), DIM_W'(dim),
         COORD_W'($urandom_range(0, 65535)), CNT_W'(sample));
  endtask

  // Drop start and hold off until every owed sample is back and the block idles.
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic configure(int unsigned oc, int unsigned pc);
    drain();
    write_reg(CFG_OUT_COUNT, oc);
    write_reg(CFG_POINT_COUNT, pc);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item();
    int unsigned r;
    int unsigned oc;
    int unsigned n;
    int unsigned dim;
    int unsigned sample;
    r = $urandom_range(0, 99);
    oc = board.out_count;
    n = board.points_used();
    dim = $urandom_range(0, MAX_DIMS - 1);
    if (r < 25) begin
      // Refresh a point: mostly inside the active trajectory.
      if ($urandom_range(0, 9) < 7)
        load($urandom_range(0, n - 1), dim, COORD_W'($urandom_range(0, 65535)));
      else
        load($urandom_range(0, MAX_POINTS - 1), dim, COORD_W'($urandom_range(0, 65535)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 8 || oc == 0) sample = 0;
    else if (r < 16) sample = oc - 1;
    else if (r < 30) sample = (oc >= 65535) ? 65535 : $urandom_range(oc, 65535);
    else sample = $urandom_range(0, oc - 1);
    query(sample, dim);
  endtask

  initial begin
    int unsigned oc;
    int unsigned pc;
    board = new();
    calm_left = 0;
    settings_used = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    kind         <= KIND_LOAD;
    point_index  <= '0;
    dim_index    <= '0;
    coord_in     <= '0;
    sample_index <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_OUT_COUNT;
    cfg_data     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset counts, one in range and two past the end.
    query(0, 0);
    query(1, 0);
    query(65535, 3);

    // Zero output samples: every query is out of range.
    configure(0, 1);
    query(0, 1);

    // Two points at opposite extremes, interpolated both ways, plus the
    // last-point and zero-fraction cases.
    configure(3, 2);
    load(0, 0, 16'sh8000);
    load(1, 0, 16'sh7FFF);
    query(1, 0);
    query(2, 0);
    load(0, 1, 16'sh7FFF);
    load(1, 1, 16'sh8000);
    query(1, 1);
    query(0, 1);

    // Zero point count acts as a single point.
    configure(3, 0);
    query(2, 2);

    // Point count above the store saturates; widest output count.
    configure(65535, 2047);
    load(1023, 3, 16'sh8000);
    query(65534, 3);
    query(32768, 2);

    configure(65535, 1024);
    load(1023, 0, 16'sh7FFF);
    query(65534, 0);
    query(65533, 0);

    // Random phases over a spread of settings, extremes first.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin oc = 65535; pc = 1024; end
        1: begin oc = 1; pc = 1; end
        2: begin oc = 1; pc = 1024; end
        3: begin oc = 65535; pc = 1; end
        4: begin oc = $urandom_range(2, 40); pc = $urandom_range(2, 16); end
        5: begin oc = $urandom_range(2, 16); pc = $urandom_range(16, 64); end
        6: begin oc = $urandom_range(1000, 65535); pc = $urandom_range(2, 1024); end
        default: begin oc = $urandom_range(2, 200); pc = $urandom_range(2, 200); end
      endcase
      configure(oc, pc);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // On odd phases, pause mid-phase until every owed sample is back.
        if (i == ITEMS_PER_PHASE / 2 && ph[0]) drain();
        random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.close();
    $display("Covered %0d loads and %0d queries (%0d past the sample range) under %0d settings.",
             board.loads, board.queries, board.out_of_range, settings_used);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
